[hdl/lzwd_pkg.sv]
// shared constants for the lzw code decoder
// no dependencies; used by the interfaces, the dictionary and the top level
`timescale 1ns / 1ps

package lzwd_pkg;

  localparam int CODE_W            = 16;
  localparam int CNT_W             = 17;
  localparam int WIDTH_W           = 5;
  localparam int BYTE_W            = 8;
  localparam int DEPTH_W           = 16;
  localparam int STK_AW            = 6;
  localparam int DEF_MAX_CODE_BITS = 16;

  localparam logic [CODE_W-1:0]  END_CODE    = CODE_W'(256);
  localparam logic [CNT_W-1:0]   FIRST_FREE  = CNT_W'(257);
  localparam logic [CNT_W-1:0]   COUNT_CEIL  = CNT_W'(65536);
  localparam logic [CNT_W-1:0]   TRC_RESET   = CNT_W'(65536);
  localparam logic [WIDTH_W-1:0] START_WIDTH = WIDTH_W'(9);
  localparam int                 START_LIMIT = 512;
  localparam logic [DEPTH_W-1:0] WALK_MAX    = DEPTH_W'(65535);
  localparam logic [STK_AW-1:0]  POP_MAX     = STK_AW'(63);

endpackage

[hdl/lzwd_ifs.sv]
// valid/ready channels of the lzw code decoder: code input, byte output, configuration
// depends on lzwd_pkg
`timescale 1ns / 1ps

interface lzwd_code_if;
  import lzwd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_word;
  modport source (output valid, output code_word, input ready);
  modport sink   (input valid, input code_word, output ready);
endinterface

interface lzwd_byte_if;
  import lzwd_pkg::*;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               last_of_code;
  logic               end_of_stream;
  logic [WIDTH_W-1:0] next_width;
  modport source (output valid, output out_byte, output last_of_code,
                  output end_of_stream, output next_width, input ready);
  modport sink   (input valid, input out_byte, input last_of_code,
                  input end_of_stream, input next_width, output ready);
endinterface

interface lzwd_cfg_if;
  import lzwd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] table_reset_count;
  modport source (output valid, output table_reset_count, input ready);
  modport sink   (input valid, input table_reset_count, output ready);
endinterface

[hdl/lzw_code_decoder.sv]
// lzw code decoder top level: sequencer, chain walk, byte stack and output register
// depends on lzwd_pkg, lzwd_ifs and lzwd_dict
`timescale 1ns / 1ps

// Takes one unpacked LZW code per item and returns its decoded string one byte per
// result, first byte first, with the code width for the next code on every result.
// One item is taken at a time. A literal or end code is sent from its own state. Any
// other code passes through lookup, a walk of its prefix chain, the dictionary update
// and its first byte; the walk reads the dictionary memory one entry per cycle.
// Each further byte is taken from the 64-entry byte stack, paced by its registered
// read; the repeated first byte of an undefined code follows them. Output stalls
// hold each state that sends a byte. A result may wait in the output register while
// the next code is taken. Strings are cut after 64 bytes. Code 256 outside the literal
// state ends the stream; later codes are taken and dropped until reset. The reset
// count may be written whenever the block is idle.
module lzw_code_decoder #(
  parameter int MAX_CODE_BITS = lzwd_pkg::DEF_MAX_CODE_BITS
) (
  input  logic clk,
  input  logic rst_n,
  lzwd_code_if.sink   in_chan,
  lzwd_byte_if.source out_chan,
  lzwd_cfg_if.sink    cfg_chan
);
  import lzwd_pkg::*;

  localparam int AW    = MAX_CODE_BITS;
  localparam int LIM_W = MAX_CODE_BITS + 1;
  localparam int STK_DEPTH = 1 << STK_AW;
  localparam logic [CNT_W-1:0] TBL_DEPTH = CNT_W'(1) << MAX_CODE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_LIT, S_ENDS, S_LOOKUP, S_WALK, S_UPDATE, S_FIRST, S_POP, S_POP_WAIT, S_EXTRA
  } state_t;

  state_t             state_r;
  logic [CODE_W-1:0]  code_r;
  logic [CODE_W-1:0]  prev_r;
  logic [CNT_W-1:0]   nfc_r;
  logic [WIDTH_W-1:0] width_r;
  logic [LIM_W-1:0]   limit_r;
  logic               expect_r;
  logic               done_r;
  logic [CNT_W-1:0]   trc_r;
  logic               undef_r;
  logic [BYTE_W-1:0]  first_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [STK_AW-1:0]  pops_r;
  logic [STK_AW-1:0]  pop_ptr_r;
  logic               extra_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_last_r;
  logic               out_eos_r;
  logic [WIDTH_W-1:0] out_width_r;

  logic [BYTE_W-1:0]  stk_mem [STK_DEPTH];
  logic [BYTE_W-1:0]  stk_rd_r;

  logic               slot_free;
  logic               out_load;
  logic               undef_c;
  logic [CODE_W-1:0]  walk_start;
  logic [CODE_W-1:0]  prefix_rd;
  logic [BYTE_W-1:0]  append_rd;
  logic [AW-1:0]      rd_addr;
  logic [DEPTH_W-1:0] depth_nxt;
  logic               walk_go;
  logic [CNT_W-1:0]   nfc_nxt;
  logic               grow;
  logic [STK_AW-1:0]  pops_nxt;
  logic               dict_wr;

  assign slot_free  = !out_valid_r || out_chan.ready;
  assign out_load   = slot_free && (state_r == S_LIT || state_r == S_ENDS ||
                      state_r == S_FIRST || state_r == S_POP || state_r == S_EXTRA);
  assign undef_c    = {1'b0, code_r} >= nfc_r;
  assign walk_start = undef_c ? prev_r : code_r;
  assign depth_nxt  = depth_r + 1'b1;
  assign walk_go    = (prefix_rd > END_CODE) && (depth_nxt != WALK_MAX);
  assign rd_addr    = (state_r == S_WALK) ? prefix_rd[AW-1:0] : walk_start[AW-1:0];
  assign nfc_nxt    = (nfc_r < COUNT_CEIL) ? nfc_r + 1'b1 : nfc_r;
  assign grow       = (width_r < WIDTH_W'(MAX_CODE_BITS)) &&
                      (nfc_r == CNT_W'(limit_r) - 1'b1);
  assign pops_nxt   = (depth_r > DEPTH_W'(POP_MAX)) ? POP_MAX : depth_r[STK_AW-1:0];
  assign dict_wr    = (state_r == S_UPDATE) && (nfc_r < TBL_DEPTH);

  lzwd_dict #(.ADDR_W(AW)) u_dict (
    .clk       (clk),
    .wr_en     (dict_wr),
    .wr_addr   (nfc_r[AW-1:0]),
    .wr_prefix (prev_r),
    .wr_append (first_r),
    .rd_addr   (rd_addr),
    .rd_prefix (prefix_rd),
    .rd_append (append_rd)
  );

  // byte stack, circular over the last pushed entries
  always_ff @(posedge clk) begin
    if (state_r == S_WALK) begin
      stk_mem[depth_r[STK_AW-1:0]] <= append_rd;
    end
    stk_rd_r <= stk_mem[pop_ptr_r];
  end

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_byte      = out_byte_r;
  assign out_chan.last_of_code  = out_last_r;
  assign out_chan.end_of_stream = out_eos_r;
  assign out_chan.next_width    = out_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      nfc_r       <= FIRST_FREE;
      width_r     <= START_WIDTH;
      limit_r     <= LIM_W'(START_LIMIT);
      expect_r    <= 1'b1;
      done_r      <= 1'b0;
      trc_r       <= TRC_RESET;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      pops_r      <= '0;
      pop_ptr_r   <= '0;
      extra_r     <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        trc_r <= cfg_chan.table_reset_count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            code_r <= in_chan.code_word;
            if (done_r) begin
              state_r <= S_IDLE;
            end else if (expect_r) begin
              state_r <= S_LIT;
            end else if (in_chan.code_word == END_CODE) begin
              state_r <= S_ENDS;
            end else begin
              state_r <= S_LOOKUP;
            end
          end
        end
        S_LIT: begin
          if (slot_free) begin
            out_byte_r  <= code_r[BYTE_W-1:0];
            out_last_r  <= 1'b1;
            out_eos_r   <= 1'b0;
            out_width_r <= width_r;
            prev_r      <= code_r;
            expect_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_ENDS: begin
          if (slot_free) begin
            out_byte_r  <= '0;
            out_last_r  <= 1'b0;
            out_eos_r   <= 1'b1;
            out_width_r <= width_r;
            done_r      <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_LOOKUP: begin
          undef_r <= undef_c;
          depth_r <= '0;
          if (walk_start > END_CODE) begin
            state_r <= S_WALK;
          end else begin
            first_r <= walk_start[BYTE_W-1:0];
            state_r <= S_UPDATE;
          end
        end
        S_WALK: begin
          depth_r <= depth_nxt;
          if (!walk_go) begin
            first_r <= prefix_rd[BYTE_W-1:0];
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          prev_r    <= code_r;
          pops_r    <= pops_nxt;
          pop_ptr_r <= depth_r[STK_AW-1:0] - 1'b1;
          extra_r   <= undef_r && (pops_nxt != POP_MAX);
          if (nfc_nxt == trc_r) begin
            nfc_r    <= FIRST_FREE;
            width_r  <= START_WIDTH;
            limit_r  <= LIM_W'(START_LIMIT);
            expect_r <= 1'b1;
          end else begin
            nfc_r <= nfc_nxt;
            if (dict_wr && grow) begin
              width_r <= width_r + 1'b1;
              limit_r <= limit_r << 1;
            end
          end
          state_r <= S_FIRST;
        end
        S_FIRST: begin
          if (slot_free) begin
            out_byte_r  <= first_r;
            out_last_r  <= (pops_r == '0) && !extra_r;
            out_eos_r   <= 1'b0;
            out_width_r <= width_r;
            if (pops_r != '0) begin
              state_r <= S_POP;
            end else if (extra_r) begin
              state_r <= S_EXTRA;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_POP: begin
          if (slot_free) begin
            out_byte_r  <= stk_rd_r;
            out_last_r  <= (pops_r == STK_AW'(1)) && !extra_r;
            out_eos_r   <= 1'b0;
            out_width_r <= width_r;
            pops_r      <= pops_r - 1'b1;
            pop_ptr_r   <= pop_ptr_r - 1'b1;
            if (pops_r == STK_AW'(1)) begin
              state_r <= extra_r ? S_EXTRA : S_IDLE;
            end else begin
              state_r <= S_POP_WAIT;
            end
          end
        end
        S_POP_WAIT: begin
          state_r <= S_POP;
        end
        S_EXTRA: begin
          if (slot_free) begin
            out_byte_r  <= first_r;
            out_last_r  <= 1'b1;
            out_eos_r   <= 1'b0;
            out_width_r <= width_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_limit_tracks_width: assert property (@(posedge clk) disable iff (!rst_n)
    limit_r == (LIM_W'(1) << width_r))
    else $error("width limit out of step with code width");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    width_r >= START_WIDTH && width_r <= WIDTH_W'(MAX_CODE_BITS))
    else $error("code width out of range");

  a_free_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    nfc_r >= FIRST_FREE && nfc_r <= COUNT_CEIL)
    else $error("next free code out of range");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("stream end flag cleared without reset");

  a_eos_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eos_r |-> done_r)
    else $error("end of stream item without stream end flag");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP || state_r == S_POP_WAIT) |-> pops_r != '0)
    else $error("stack pop with nothing left to send");

endmodule

[hdl/lzwd_dict.sv]
// dictionary memories: prefix code and appended byte per entry
// one write port, one read port with registered read data; depends on lzwd_pkg
`timescale 1ns / 1ps

module lzwd_dict #(
  parameter int ADDR_W = lzwd_pkg::DEF_MAX_CODE_BITS
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [lzwd_pkg::CODE_W-1:0] wr_prefix,
  input  logic [lzwd_pkg::BYTE_W-1:0] wr_append,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [lzwd_pkg::CODE_W-1:0] rd_prefix,
  output logic [lzwd_pkg::BYTE_W-1:0] rd_append
);
  import lzwd_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [CODE_W-1:0] prefix_mem [DEPTH];
  logic [BYTE_W-1:0] append_mem [DEPTH];
  logic [CODE_W-1:0] rd_prefix_r;
  logic [BYTE_W-1:0] rd_append_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prefix_mem[wr_addr] <= wr_prefix;
      append_mem[wr_addr] <= wr_append;
    end
    rd_prefix_r <= prefix_mem[rd_addr];
    rd_append_r <= append_mem[rd_addr];
  end

  assign rd_prefix = rd_prefix_r;
  assign rd_append = rd_append_r;

endmodule
